[src/rmq_pkg.sv]
// Package with shared types and constants of the range-mode query block.
package rmq_pkg;

    localparam int ValueWidth = 32;
    localparam int CountWidth = 11;
    localparam int IndexWidth = 10;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic                  command;
        logic [IndexWidth-1:0] position;
        logic [ValueWidth-1:0] value;
        logic [IndexWidth-1:0] left;
        logic [IndexWidth-1:0] right;
    } rmq_in_t;

    typedef struct packed {
        logic [ValueWidth-1:0] mode_value;
        logic [CountWidth-1:0] mode_count;
        logic                  range_error;
    } rmq_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_item;   // capture the input transaction
        logic write_mem;   // write the load into the store
        logic start_outer; // i = lo, clear best
        logic start_inner; // clear count, latch candidate, advance j
        logic rd_outer;    // read address is i, j = lo
        logic step_inner;  // accumulate one compare, advance j
        logic finish_cand; // compare candidate with best, advance i
        logic set_error;   // result is the range error
        logic load_out;    // move the result to the output register
    } rmq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_query;
        logic out_of_range;
        logic inner_last;
        logic outer_last;
    } rmq_stat_t;

endpackage

[src/rmq_if.sv]
// Valid/ready channel interface carrying one payload.
interface rmq_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[src/range_mode_query.sv]
// Top level of the range-mode query block.
//
// Input channel in_ch carries a load or a query; output channel out_ch
// carries one result per query and none per load. cfg_ch writes the
// element count. A load writes one element of the store and then frees
// the block. The length of a query search over n = hi-lo+1 elements is
// set by the single read port of the element store, which serves both
// the candidate loop and the counting loop, one element per cycle.
// Out-of-range queries answer without a search, with range_error set.
// The block works on one item at a time; in_ch.ready is high only when idle.
// The finished result waits in an output register; while the receiver
// stalls, the block accepts the next item and stops only when a new result
// would overwrite the waiting one.
// Reset clears control and sets the element count to 1; the store is
// undefined until written and needs no clearing pass.
module range_mode_query #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  logic  clk,
    input  logic  rst_n,
    rmq_if.sink   in_ch,
    rmq_if.source out_ch,
    rmq_if.sink   cfg_ch
);
    import rmq_pkg::*;

    logic [CountWidth-1:0] element_count_reg;
    rmq_cmd_t              cmd;
    rmq_stat_t             stat;
    rmq_out_t              result;
    rmq_in_t               in_item;

    assign in_item = in_ch.payload;

    // Element count register.
    assign cfg_ch.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            element_count_reg <= CountWidth'(1);
        end
        else if (cfg_ch.valid)
        begin
            element_count_reg <= CountWidth'(cfg_ch.payload);
        end
    end

    rmq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    rmq_dp #(
        .MaxElements (MAX_ELEMENTS)
    ) u_dp (
        .clk           (clk),
        .element_count (element_count_reg),
        .in_item       (in_item),
        .cmd           (cmd),
        .stat          (stat),
        .result        (result)
    );

    assign out_ch.payload = result;

    // A result is never written while the previous one waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.payload))
        else $error("waiting result changed");

    // Input is taken only when the controller is idle and not computing.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take_item |-> in_ch.ready)
        else $error("item taken while busy");

    // An error result carries no mode.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.payload.range_error |-> out_ch.payload.mode_count == 0)
        else $error("error result with a count");
endmodule

[src/rmq_ram.sv]
// Generic single-port RAM with registered read.
module rmq_ram #(
    parameter int Width = 32,
    parameter int Depth = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    // One address per cycle: an optional write, and a read that returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

[src/rmq_ctrl.sv]
// Controller state machine of the range-mode query block.
module rmq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  rmq_pkg::rmq_stat_t stat,
    output rmq_pkg::rmq_cmd_t  cmd
);
    import rmq_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_OREAD  = 3'd2;
    localparam logic [2:0] S_OWAIT  = 3'd3;
    localparam logic [2:0] S_INNER  = 3'd4;
    localparam logic [2:0] S_CAND   = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    // The output register must be free before a new result is written.
    logic out_free;
    assign out_free = !out_valid_reg || out_ready;

    // Next state and commands.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take_item = 1'b1;
                    state_next    = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (!stat.is_query)
                begin
                    cmd.write_mem = 1'b1;
                    state_next    = S_IDLE;
                end
                else if (stat.out_of_range)
                begin
                    cmd.set_error = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    cmd.start_outer = 1'b1;
                    state_next      = S_OREAD;
                end
            end
            S_OREAD:
            begin
                cmd.rd_outer = 1'b1;
                state_next   = S_OWAIT;
            end
            S_OWAIT:
            begin
                cmd.start_inner = 1'b1;
                state_next      = S_INNER;
            end
            S_INNER:
            begin
                cmd.step_inner = 1'b1;
                if (stat.inner_last)
                begin
                    state_next = S_CAND;
                end
            end
            S_CAND:
            begin
                cmd.finish_cand = 1'b1;
                state_next      = stat.outer_last ? S_DONE : S_OREAD;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
endmodule

[src/rmq_dp.sv]
// Datapath of the range-mode query block: store, counters and best tracker.
module rmq_dp #(
    parameter int MaxElements = 1024
) (
    input  logic                           clk,
    input  logic [rmq_pkg::CountWidth-1:0] element_count,
    input  rmq_pkg::rmq_in_t               in_item,
    input  rmq_pkg::rmq_cmd_t              cmd,
    output rmq_pkg::rmq_stat_t             stat,
    output rmq_pkg::rmq_out_t              result
);
    import rmq_pkg::*;

    localparam int AddrWidth = $clog2(MaxElements);
    localparam int CntWidth  = $clog2(MaxElements + 1);

    rmq_in_t              item_reg;
    logic [IndexWidth-1:0] lo_reg, hi_reg, i_reg, j_reg;
    logic [ValueWidth-1:0] cand_reg, best_val_reg;
    logic [CntWidth-1:0]   cnt_reg, best_cnt_reg;
    logic                  err_reg;
    rmq_out_t              result_reg;

    logic [IndexWidth-1:0] lo_w, hi_w, addr_idx;
    logic [ValueWidth-1:0] rdata;
    logic [AddrWidth-1:0]  addr;
    logic [CntWidth:0]     active;
    logic                  pos_ok;

    // Ordered bounds and the saturated element count.
    assign lo_w = (item_reg.left > item_reg.right) ? item_reg.right : item_reg.left;
    assign hi_w = (item_reg.left > item_reg.right) ? item_reg.left : item_reg.right;
    assign active = (32'(element_count) > MaxElements) ? (CntWidth+1)'(MaxElements)
                                                       : (CntWidth+1)'(element_count);
    assign pos_ok = 32'(item_reg.position) < MaxElements;

    // Store address: the load position, the outer index or the inner index.
    always_comb
    begin
        if (cmd.write_mem)
        begin
            addr_idx = item_reg.position;
        end
        else if (cmd.rd_outer)
        begin
            addr_idx = i_reg;
        end
        else
        begin
            addr_idx = j_reg;
        end
    end
    assign addr = AddrWidth'(addr_idx);

    rmq_ram #(
        .Width (ValueWidth),
        .Depth (MaxElements)
    ) u_store (
        .clk   (clk),
        .we    (cmd.write_mem && pos_ok),
        .addr  (addr),
        .wdata (item_reg.value),
        .rdata (rdata)
    );

    // Inner scan: the read for j is issued while j advances, so the data in
    // rdata during a step belongs to the index one behind.
    always_ff @(posedge clk)
    begin
        if (cmd.take_item)
        begin
            item_reg <= in_item;
        end
        if (cmd.start_outer)
        begin
            lo_reg       <= lo_w;
            hi_reg       <= hi_w;
            i_reg        <= lo_w;
            best_val_reg <= '0;
            best_cnt_reg <= '0;
            err_reg      <= 1'b0;
        end
        if (cmd.set_error)
        begin
            err_reg      <= 1'b1;
            best_val_reg <= '0;
            best_cnt_reg <= '0;
        end
        if (cmd.rd_outer)
        begin
            j_reg <= lo_reg;
        end
        if (cmd.start_inner)
        begin
            cand_reg <= rdata;
            cnt_reg  <= '0;
            j_reg    <= j_reg + 1'b1;
        end
        if (cmd.step_inner)
        begin
            // rdata holds element j-1.
            if (rdata == cand_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            j_reg <= j_reg + 1'b1;
        end
        if (cmd.finish_cand)
        begin
            if (cnt_reg > best_cnt_reg
                || (cnt_reg == best_cnt_reg && cand_reg < best_val_reg))
            begin
                best_cnt_reg <= cnt_reg;
                best_val_reg <= cand_reg;
            end
            i_reg <= i_reg + 1'b1;
        end
        if (cmd.load_out)
        begin
            result_reg.mode_value  <= best_val_reg;
            result_reg.mode_count  <= CountWidth'(best_cnt_reg);
            result_reg.range_error <= err_reg;
        end
    end

    // During start_inner the read address is lo (j_reg), so the first step
    // sees element lo; each step compares the element read in the previous cycle.
    // The last step is the one that compares element hi, read at j == hi.
    assign stat.is_query     = (item_reg.command == CMD_QUERY);
    assign stat.out_of_range = ({1'b0, hi_w} >= (IndexWidth+1)'(active));
    assign stat.inner_last   = (IndexWidth'(j_reg - 1'b1) == hi_reg);
    assign stat.outer_last   = (i_reg == hi_reg);
    assign result = result_reg;
endmodule
